/* hdl/chbf_pkg.sv */
// Shared types and constants for the chunked body framer.
package chbf_pkg;

  // Field widths fixed by the interface
  localparam int unsigned SRC_COUNT_W    = 20;
  localparam int unsigned CFG_W          = 20;
  localparam int unsigned COUNT_BITS_DEF = 20;

  // chunk_size after reset
  localparam logic [CFG_W-1:0] CHUNK_SIZE_RST = 20'd4096;

  // One request from the upstream side
  typedef struct packed {
    logic [SRC_COUNT_W-1:0] source_count;
    logic                   source_exhausted;
    logic                   source_has_byte;
    logic [7:0]             source_byte;
  } item_t;

  // One framed result
  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       source_taken;
    logic       stream_done;
  } res_t;

endpackage

/* hdl/http_chunked_body_framer_unit.sv */
// Top level of the HTTP chunked body framer.
//
// Each input transaction is one request for one framed byte; each produces
// exactly one result transaction (out_valid_o tells whether a byte was made).
// Input channel: in_valid_i / in_stall_o; result channel: res_valid_o /
// res_stall_i. A transaction moves on an edge with valid high and stall low.
// The chunk_size register is written through cfg_valid_i / cfg_ready_o /
// cfg_data_i; the user must write it only while no requests are in flight,
// as the block itself does not enforce this; cfg_ready_o is always high.
// Throughput is one request per cycle while the output buffer is not full:
// the request register feeds the framing logic, whose result lands in a
// two-entry output buffer. When the receiver stalls, the buffer fills and the
// request register holds; in_stall_o is high only while both buffer entries
// are occupied and a request is waiting in the request register.
// Reset clears all framing state (no header prepared), empties the buffer and
// sets chunk_size to 4096.
module http_chunked_body_framer_unit #(
  parameter int unsigned COUNT_BITS = chbf_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [chbf_pkg::CFG_W-1:0]       cfg_data_i,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [chbf_pkg::SRC_COUNT_W-1:0] source_count_i,
  input  logic                             source_exhausted_i,
  input  logic                             source_has_byte_i,
  input  logic [7:0]                       source_byte_i,
  // result channel
  output logic                             res_valid_o,
  input  logic                             res_stall_i,
  output logic                             out_valid_o,
  output logic [7:0]                       out_byte_o,
  output logic                             source_taken_o,
  output logic                             stream_done_o
);
  import chbf_pkg::*;

  logic  in_vld_q, in_vld_d;
  item_t item_q;
  logic  accept, step, buf_full;
  res_t  core_res, out_res;

  assign cfg_ready_o = 1'b1;

  // Request register
  assign in_stall_o = in_vld_q && buf_full;
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = in_vld_q && !buf_full;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (step) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.source_count     <= source_count_i;
      item_q.source_exhausted <= source_exhausted_i;
      item_q.source_has_byte  <= source_has_byte_i;
      item_q.source_byte      <= source_byte_i;
    end
  end

  // Framing logic
  chbf_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .step_i     (step),
    .item_i     (item_q),
    .res_o      (core_res)
  );

  // Result buffer
  chbf_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .data_i  (core_res),
    .full_o  (buf_full),
    .valid_o (res_valid_o),
    .stall_i (res_stall_i),
    .data_o  (out_res)
  );

  assign out_valid_o    = out_res.out_valid;
  assign out_byte_o     = out_res.out_byte;
  assign source_taken_o = out_res.source_taken;
  assign stream_done_o  = out_res.stream_done;

endmodule

/* hdl/chbf_core.sv */
// Framing state machine: turns one registered request into one result.
module chbf_core #(
  parameter int unsigned COUNT_BITS = chbf_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [chbf_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         step_i,
  input  chbf_pkg::item_t              item_i,
  output chbf_pkg::res_t               res_o
);
  import chbf_pkg::*;

  localparam int unsigned CW  = COUNT_BITS;
  localparam int unsigned MW  = (CW > CFG_W) ? CW : CFG_W;
  localparam int unsigned NIB = (CW + 3) / 4;

  // Phase codes
  localparam logic [2:0] PH_UNPREP = 3'd0;
  localparam logic [2:0] PH_DIGITS = 3'd1;
  localparam logic [2:0] PH_HTAIL  = 3'd2;
  localparam logic [2:0] PH_BODY   = 3'd3;
  localparam logic [2:0] PH_CRLF   = 3'd4;
  localparam logic [2:0] PH_FINAL  = 3'd5;
  localparam logic [2:0] PH_DONE   = 3'd6;
  localparam logic [2:0] PH_SPARE  = 3'd7;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // Bytes of the terminating chunk "0" CR LF CR LF
  function automatic logic [7:0] final_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = CH_ZERO;
      3'd1:    b = CH_CR;
      3'd2:    b = CH_LF;
      3'd3:    b = CH_CR;
      default: b = CH_LF;
    endcase
    return b;
  endfunction

  logic [CFG_W-1:0] chunk_size_q;
  logic [2:0]       phase_q, phase_d;
  logic [CW-1:0]    len_q, len_d;
  logic [CW-1:0]    left_q, left_d;
  logic [2:0]       di_q, di_d;
  logic             hti_q, hti_d;
  logic             crlf_q, crlf_d;
  logic [2:0]       fi_q, fi_d;

  // Chunk set-up from the current request
  logic [CW-1:0]    cnt;
  logic [CFG_W-1:0] cs_eff;
  logic [MW-1:0]    cnt_m, cs_m;
  logic [CW-1:0]    prep_len;
  logic             prep_ok;

  assign cnt      = CW'(item_i.source_count);
  assign cs_eff   = (chunk_size_q == '0) ? 20'd1 : chunk_size_q;
  assign cnt_m    = MW'(cnt);
  assign cs_m     = MW'(cs_eff);
  assign prep_len = CW'((cnt_m < cs_m) ? cnt_m : cs_m);
  assign prep_ok  = (cnt != '0);

  // Hex digit selection for the length being printed
  logic             unprep;
  logic [CW-1:0]    eff_len;
  logic [2:0]       eff_di;
  logic [4*NIB-1:0] len_pad;
  logic [3:0]       nd, d_ext, sel, nib;
  logic             digit_last;
  logic [7:0]       digit_ch;

  assign unprep  = (phase_q == PH_UNPREP);
  assign eff_len = unprep ? prep_len : len_q;
  assign eff_di  = unprep ? 3'd0 : di_q;
  assign len_pad = (4*NIB)'(eff_len);
  assign d_ext   = {1'b0, eff_di};

  always_comb begin
    nd = 4'd1;
    for (int k = 1; k < NIB; k++) begin
      if (len_pad[4*k +: 4] != 4'h0) nd = 4'(k + 1);
    end
    sel = (d_ext < nd) ? (nd - 4'd1 - d_ext) : 4'd0;
    nib = 4'h0;
    for (int k = 0; k < NIB; k++) begin
      if (sel == 4'(k)) nib = len_pad[4*k +: 4];
    end
  end

  assign digit_last = ((d_ext + 4'd1) >= nd);
  assign digit_ch   = (nib < 4'd10) ? (8'h30 + {4'h0, nib}) : (8'h57 + {4'h0, nib});

  // Next state and result
  logic [2:0]    fi_cl;
  logic [CW-1:0] left_new;

  always_comb begin
    phase_d  = phase_q;
    len_d    = len_q;
    left_d   = left_q;
    di_d     = di_q;
    hti_d    = hti_q;
    crlf_d   = crlf_q;
    fi_d     = fi_q;
    res_o    = '0;
    fi_cl    = (fi_q > 3'd4) ? 3'd4 : fi_q;
    left_new = (left_q != '0) ? (left_q - CW'(1)) : left_q;

    // no header prepared yet: set one up from this request
    if (unprep) begin
      if (prep_ok) begin
        phase_d = PH_DIGITS;
        len_d   = prep_len;
        left_d  = prep_len;
        di_d    = 3'd0;
        hti_d   = 1'b0;
      end else if (item_i.source_exhausted) begin
        phase_d = PH_FINAL;
        fi_d    = 3'd0;
        fi_cl   = 3'd0;
      end
    end

    case (phase_d)
      PH_DIGITS: begin
        res_o.out_valid = 1'b1;
        res_o.out_byte  = digit_ch;
        if (digit_last) begin
          phase_d = PH_HTAIL;
          hti_d   = 1'b0;
        end else begin
          di_d = eff_di + 3'd1;
        end
      end
      PH_HTAIL: begin
        res_o.out_valid = 1'b1;
        if (!hti_q) begin
          res_o.out_byte = CH_CR;
          hti_d          = 1'b1;
        end else begin
          res_o.out_byte = CH_LF;
          hti_d          = 1'b0;
          phase_d        = PH_BODY;
        end
      end
      PH_BODY: begin
        if (item_i.source_has_byte) begin
          res_o.out_valid    = 1'b1;
          res_o.source_taken = 1'b1;
          res_o.out_byte     = item_i.source_byte;
          left_d             = left_new;
          if (left_new == '0) begin
            phase_d = PH_CRLF;
            crlf_d  = 1'b0;
          end
        end
      end
      PH_CRLF: begin
        res_o.out_valid = 1'b1;
        if (!crlf_q) begin
          res_o.out_byte = CH_CR;
          crlf_d         = 1'b1;
        end else begin
          res_o.out_byte = CH_LF;
          crlf_d         = 1'b0;
          // closing LF: set up the next header, the final chunk or the idle state from this request
          if (prep_ok) begin
            phase_d = PH_DIGITS;
            len_d   = prep_len;
            left_d  = prep_len;
            di_d    = 3'd0;
            hti_d   = 1'b0;
          end else if (item_i.source_exhausted) begin
            phase_d = PH_FINAL;
            fi_d    = 3'd0;
          end else begin
            phase_d = PH_UNPREP;
          end
        end
      end
      PH_FINAL: begin
        res_o.out_valid = 1'b1;
        res_o.out_byte  = final_byte(fi_cl);
        fi_d            = fi_cl + 3'd1;
        if (fi_cl == 3'd4) phase_d = PH_DONE;
      end
      default: begin
      end
    endcase

    res_o.stream_done = (phase_d == PH_DONE) || (phase_d == PH_SPARE);
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_size_q <= CHUNK_SIZE_RST;
    end else if (cfg_we_i) begin
      chunk_size_q <= cfg_data_i;
    end
  end

  // Framing state, advanced once per processed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_UNPREP;
      len_q   <= '0;
      left_q  <= '0;
      di_q    <= 3'd0;
      hti_q   <= 1'b0;
      crlf_q  <= 1'b0;
      fi_q    <= 3'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      len_q   <= len_d;
      left_q  <= left_d;
      di_q    <= di_d;
      hti_q   <= hti_d;
      crlf_q  <= crlf_d;
      fi_q    <= fi_d;
    end
  end

  // Termination is permanent
  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE || phase_q == PH_SPARE) |=>
    (phase_q == PH_DONE || phase_q == PH_SPARE))
    else $error("framer left the done phase");

  // A body phase always has bytes still owed
  a_body_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_BODY) |-> (left_q != '0))
    else $error("body phase with no bytes left");

  // Consuming a source byte always emits it
  a_taken_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> (!res_o.source_taken || res_o.out_valid))
    else $error("source byte taken without output");

endmodule

/* hdl/chbf_out_buf.sv */
// Two-entry result buffer: output register plus skid stage.
module chbf_out_buf (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  chbf_pkg::res_t  data_i,
  output logic            full_o,
  output logic            valid_o,
  input  logic            stall_i,
  output chbf_pkg::res_t  data_o
);
  import chbf_pkg::*;

  logic hd_vld_q, hd_vld_d;
  logic sk_vld_q, sk_vld_d;
  res_t hd_q, hd_d;
  res_t sk_q, sk_d;
  logic pop;

  assign pop     = hd_vld_q && !stall_i;
  assign full_o  = sk_vld_q;
  assign valid_o = hd_vld_q;
  assign data_o  = hd_q;

  // Keep order: skid entry moves forward before new data
  always_comb begin
    hd_vld_d = hd_vld_q;
    sk_vld_d = sk_vld_q;
    hd_d     = hd_q;
    sk_d     = sk_q;
    if (pop) begin
      if (sk_vld_q) begin
        hd_d = sk_q;
        if (push_i) begin
          sk_d = data_i;
        end else begin
          sk_vld_d = 1'b0;
        end
      end else if (push_i) begin
        hd_d = data_i;
      end else begin
        hd_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!hd_vld_q) begin
        hd_d     = data_i;
        hd_vld_d = 1'b1;
      end else begin
        sk_d     = data_i;
        sk_vld_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hd_vld_q <= 1'b0;
      sk_vld_q <= 1'b0;
    end else begin
      hd_vld_q <= hd_vld_d;
      sk_vld_q <= sk_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hd_q <= hd_d;
    sk_q <= sk_d;
  end

  // Skid entry only exists behind a waiting head
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_vld_q |-> hd_vld_q)
    else $error("skid entry without head entry");

  // Upstream never pushes into a full buffer
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !sk_vld_q)
    else $error("push into full result buffer");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the HTTP chunked body framer unit.
`timescale 1ns / 1ps

module testbench;
  import chbf_pkg::*;

  // Framer phases as tracked by the bench predictor
  typedef enum logic [2:0] {
    FR_IDLE, FR_DIGITS, FR_HDR_CRLF, FR_BODY, FR_TRL_CRLF, FR_LAST, FR_DONE
  } frame_phase_e;

  // Request paired with the framed byte it should produce
  typedef struct packed {
    item_t req;
    res_t  want;
  } req_pair_t;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned MAX_PRINTS  = 40;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [SRC_COUNT_W-1:0] source_count_i = '0;
  logic                   source_exhausted_i = 1'b0;
  logic                   source_has_byte_i = 1'b0;
  logic [7:0]             source_byte_i = '0;
  logic                   res_valid_o;
  logic                   res_stall_i = 1'b0;
  logic                   out_valid_o;
  logic [7:0]             out_byte_o;
  logic                   source_taken_o;
  logic                   stream_done_o;

  http_chunked_body_framer_unit u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .source_count_i     (source_count_i),
    .source_exhausted_i (source_exhausted_i),
    .source_has_byte_i  (source_has_byte_i),
    .source_byte_i      (source_byte_i),
    .res_valid_o        (res_valid_o),
    .res_stall_i        (res_stall_i),
    .out_valid_o        (out_valid_o),
    .out_byte_o         (out_byte_o),
    .source_taken_o     (source_taken_o),
    .stream_done_o      (stream_done_o)
  );

  // 12 ns clock
  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // Predictor state, tracked at the time requests are queued
  logic [CFG_W-1:0]       chunk_cfg   = CHUNK_SIZE_RST;
  frame_phase_e           fr_phase    = FR_IDLE;
  logic [SRC_COUNT_W-1:0] fr_len      = '0;
  logic [SRC_COUNT_W-1:0] fr_left     = '0;
  logic [2:0]             fr_digit    = '0;
  logic                   fr_hdr_lf   = 1'b0;
  logic                   fr_trl_lf   = 1'b0;
  logic [2:0]             fr_last_idx = '0;

  req_pair_t request_q[$];
  res_t      framed_exp_q[$];
  req_pair_t nxt;
  res_t      drv_want;
  res_t      got;
  res_t      exp_res;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cnt  = 0;
  int unsigned err_count  = 0;
  bit          idle_off   = 1'b0;

  // Start a new chunk, the final chunk, or nothing
  function automatic void setup_chunk(logic [SRC_COUNT_W-1:0] cnt, logic exh);
    logic [SRC_COUNT_W-1:0] cs;
    if (cnt == '0) begin
      if (exh) begin
        fr_phase    = FR_LAST;
        fr_last_idx = '0;
      end else begin
        fr_phase = FR_IDLE;
      end
    end else begin
      cs        = (chunk_cfg == '0) ? 20'd1 : chunk_cfg;
      fr_len    = (cnt < cs) ? cnt : cs;
      fr_left   = fr_len;
      fr_digit  = '0;
      fr_hdr_lf = 1'b0;
      fr_phase  = FR_DIGITS;
    end
  endfunction

  // One request through the framer: returns the byte it should emit
  function automatic res_t frame_step(item_t it);
    res_t        r;
    int unsigned nd;
    int unsigned sh;
    logic [3:0]  nib;
    r = '0;
    if (fr_phase == FR_IDLE) setup_chunk(it.source_count, it.source_exhausted);
    case (fr_phase)
      FR_DIGITS: begin
        nd = 1;
        while (nd < 5 && (fr_len >> (4 * nd)) != '0) nd++;
        sh  = (fr_digit < nd) ? 4 * (nd - 1 - fr_digit) : 0;
        nib = 4'((fr_len >> sh) & 20'hF);
        r.out_valid = 1'b1;
        r.out_byte  = (nib < 10) ? {4'h3, nib} : 8'h57 + {4'h0, nib};
        if (fr_digit + 1 >= nd) begin
          fr_phase  = FR_HDR_CRLF;
          fr_hdr_lf = 1'b0;
        end else begin
          fr_digit = fr_digit + 3'd1;
        end
      end
      FR_HDR_CRLF: begin
        r.out_valid = 1'b1;
        if (!fr_hdr_lf) begin
          r.out_byte = CH_CR;
          fr_hdr_lf  = 1'b1;
        end else begin
          r.out_byte = CH_LF;
          fr_hdr_lf  = 1'b0;
          fr_phase   = FR_BODY;
        end
      end
      FR_BODY: begin
        // a source with no byte leaves everything as it was
        if (it.source_has_byte) begin
          r.out_valid    = 1'b1;
          r.source_taken = 1'b1;
          r.out_byte     = it.source_byte;
          if (fr_left > 0) fr_left = fr_left - 20'd1;
          if (fr_left == 0) begin
            fr_phase  = FR_TRL_CRLF;
            fr_trl_lf = 1'b0;
          end
        end
      end
      FR_TRL_CRLF: begin
        r.out_valid = 1'b1;
        if (!fr_trl_lf) begin
          r.out_byte = CH_CR;
          fr_trl_lf  = 1'b1;
        end else begin
          r.out_byte = CH_LF;
          fr_trl_lf  = 1'b0;
          setup_chunk(it.source_count, it.source_exhausted);
        end
      end
      FR_LAST: begin
        // "0" CR LF CR LF
        r.out_valid = 1'b1;
        if (fr_last_idx > 4) fr_last_idx = 3'd4;
        if (fr_last_idx == 0) r.out_byte = CH_ZERO;
        else if (fr_last_idx[0]) r.out_byte = CH_CR;
        else r.out_byte = CH_LF;
        fr_last_idx = fr_last_idx + 3'd1;
        if (fr_last_idx >= 5) fr_phase = FR_DONE;
      end
      default: ;
    endcase
    r.stream_done = (fr_phase == FR_DONE);
    return r;
  endfunction

  // Next request sets up a header from its own fields
  function automatic bit at_prepare();
    return fr_phase == FR_IDLE || (fr_phase == FR_TRL_CRLF && fr_trl_lf);
  endfunction

  // Chunk length for a fresh header: mostly short, now and then the extremes
  function automatic logic [SRC_COUNT_W-1:0] pick_count();
    int unsigned            r;
    logic [SRC_COUNT_W-1:0] c;
    logic [SRC_COUNT_W-1:0] cs;
    r  = $urandom_range(0, 99);
    cs = (chunk_cfg == '0) ? 20'd1 : chunk_cfg;
    if (r < 8) c = '0;
    else if (r < 60) c = 20'($urandom_range(1, 24));
    else if (r < 85) c = 20'($urandom_range(1, 300));
    else if (r < 95) c = 20'($urandom_range(1, 20'hFFFFF));
    else c = 20'hFFFFF;
    // keep body lengths affordable under a large chunk size
    if (c > 400 && cs > 400) c = 20'($urandom_range(256, 400));
    return c;
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.source_count     = 20'($urandom());
    it.source_exhausted = 1'($urandom_range(0, 1));
    it.source_has_byte  = 1'($urandom_range(0, 1));
    it.source_byte      = 8'($urandom_range(0, 255));
    if (at_prepare()) begin
      // the end of stream is only signalled on purpose
      it.source_count = pick_count();
      if (it.source_count == '0) it.source_exhausted = 1'b0;
    end else if (fr_phase == FR_BODY) begin
      it.source_has_byte = ($urandom_range(0, 99) < 85);
    end
    return it;
  endfunction

  function automatic void queue_item(item_t it);
    req_pair_t p;
    p.req  = it;
    p.want = frame_step(it);
    request_q.push_back(p);
  endfunction

  function automatic void send(logic [SRC_COUNT_W-1:0] cnt, logic exh, logic hb,
                               logic [7:0] b);
    item_t it;
    it.source_count     = cnt;
    it.source_exhausted = exh;
    it.source_has_byte  = hb;
    it.source_byte      = b;
    queue_item(it);
  endfunction

  // Gap length: mostly short, a few long
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void gen_random(int unsigned n);
    repeat (n) queue_item(random_item());
  endfunction

  // One long chunk of the given length, started at the next header
  function automatic void long_chunk(logic [SRC_COUNT_W-1:0] cnt);
    while (!at_prepare()) queue_item(random_item());
    send(cnt, 1'b0, 1'b0, 8'h00);
    while (fr_phase != FR_TRL_CRLF) queue_item(random_item());
  endfunction

  task automatic report_mismatch(string what, int unsigned g, int unsigned w);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("%0t ns: %s mismatch, got %0h expected %0h", $time, what, g, w);
  endtask

  // Wait until every queued request has been framed and checked
  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || framed_exp_q.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_chunk(logic [CFG_W-1:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    chunk_cfg = v;
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) framed_exp_q.push_back(drv_want);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (request_q.size() > 0) begin
          nxt = request_q.pop_front();
          in_valid_i         <= 1'b1;
          source_count_i     <= nxt.req.source_count;
          source_exhausted_i <= nxt.req.source_exhausted;
          source_has_byte_i  <= nxt.req.source_has_byte;
          source_byte_i      <= nxt.req.source_byte;
          drv_want = nxt.want;
          if (!idle_off && $urandom_range(0, 99) < 35) gap_left = draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (res_valid_o && !res_stall_i) begin
        got = {out_valid_o, out_byte_o, source_taken_o, stream_done_o};
        if (framed_exp_q.size() == 0) begin
          report_mismatch("unexpected result", got, 0);
        end else begin
          exp_res = framed_exp_q.pop_front();
          if (got.out_valid !== exp_res.out_valid)
            report_mismatch("out_valid", got.out_valid, exp_res.out_valid);
          if (got.out_byte !== exp_res.out_byte)
            report_mismatch("out_byte", got.out_byte, exp_res.out_byte);
          if (got.source_taken !== exp_res.source_taken)
            report_mismatch("source_taken", got.source_taken, exp_res.source_taken);
          if (got.stream_done !== exp_res.stream_done)
            report_mismatch("stream_done", got.stream_done, exp_res.stream_done);
        end
      end
      if (stall_left == 0 && !idle_off && $urandom_range(0, 99) < 15)
        stall_left = draw_gap();
      if (stall_left > 0) begin
        res_stall_i <= 1'b1;
        stall_left--;
      end else begin
        res_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: too long without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (res_valid_o && !res_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cnt = 0;
      end else begin
        quiet_cnt++;
        if (quiet_cnt >= STALL_LIMIT) begin
          $display("%0t ns: no transaction for %0d cycles", $time, quiet_cnt);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  // Stimulus
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset chunk size: empty source, one-byte chunk, body stall, byte extremes
    send(20'd0, 1'b0, 1'b0, 8'h00);
    send(20'd1, 1'b0, 1'b1, 8'hFF);
    send(20'd0, 1'b1, 1'b0, 8'h00);
    send(20'd0, 1'b1, 1'b1, 8'h00);
    send(20'd5, 1'b1, 1'b0, 8'hAA);
    send(20'hFFFFF, 1'b1, 1'b1, 8'h00);
    send(20'd0, 1'b0, 1'b0, 8'h00);
    send(20'd0, 1'b0, 1'b0, 8'h00);

    // zero chunk size acts as one; maximum count, header straight after a chunk
    set_chunk(20'd0);
    send(20'hFFFFF, 1'b1, 1'b1, 8'h55);
    send(20'd0, 1'b0, 1'b0, 8'h00);
    send(20'd0, 1'b0, 1'b0, 8'h00);
    send(20'd0, 1'b0, 1'b1, 8'hFF);
    send(20'd0, 1'b0, 1'b0, 8'h00);
    send(20'd3, 1'b1, 1'b0, 8'h00);
    send(20'd0, 1'b0, 1'b0, 8'h00);
    send(20'd0, 1'b0, 1'b0, 8'h00);
    send(20'd0, 1'b0, 1'b1, 8'h80);
    send(20'd0, 1'b0, 1'b0, 8'h00);
    send(20'd0, 1'b0, 1'b0, 8'h00);

    // largest chunk size: two-digit headers with letter digits
    set_chunk(20'hFFFFF);
    idle_off = 1'b1;
    long_chunk(20'hAB);
    wait_drained();
    idle_off = 1'b0;
    long_chunk(20'h3F);

    // random phases over several chunk sizes
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: set_chunk(20'd1);
        2: set_chunk(20'($urandom_range(2, 16)));
        3: set_chunk(20'($urandom_range(17, 300)));
        4: set_chunk(20'($urandom_range(1, 20'hFFFFF)));
        5: set_chunk(CHUNK_SIZE_RST);
        default: wait_drained();
      endcase
      idle_off = (ph == 3);
      gen_random(110);
    end

    // end of stream, either from the idle state or right after a chunk
    wait_drained();
    idle_off = 1'b0;
    while (!at_prepare()) queue_item(random_item());
    if ($urandom_range(0, 1)) begin
      send(20'd0, 1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    end
    send(20'd0, 1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    while (fr_phase != FR_DONE) queue_item(random_item());
    gen_random(4);

    wait_drained();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/chbf_pkg.sv
hdl/chbf_core.sv
hdl/chbf_out_buf.sv
hdl/http_chunked_body_framer_unit.sv
bench/testbench.sv
